>>> hdl/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// shared types and constants of the box versus frustum cull engine
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int COORD_W     = 16;
    localparam int FRAC_BITS   = 14;
    localparam int PLANE_SLOTS = 6;
    localparam int PLANE_W     = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = 2 * COORD_W;
    localparam int SUM_W       = PROD_W + 3;

    localparam logic [PLANE_SLOTS-1:0] ALL_PLANES = 6'h3F;

    localparam logic [1:0] ST_CULLED  = 2'd0;
    localparam logic [1:0] ST_INSIDE  = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        t_box                   box;
        logic [PLANE_SLOTS-1:0] hint;
        logic [PLANE_SLOTS-1:0] any_in;
        logic [PLANE_SLOTS-1:0] all_in;
    } t_item;

endpackage

>>> hdl/afc_cell.sv
// ----------------------------------------------------------------------------
// afc_cell
// one plane of the chain: holds the plane, tests the far and near box corners
// in two stages and hands the item to the next cell
// ----------------------------------------------------------------------------
module afc_cell #(
    parameter int PLANE_IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_cfg_we,
    input  logic [afc_pkg::PLANE_W-1:0] i_cfg_data,
    input  logic                     i_valid,
    input  afc_pkg::t_item           i_item,
    output logic                     o_valid,
    output afc_pkg::t_item           o_item
);
    import afc_pkg::*;

    logic [PLANE_W-1:0] r_plane;

    logic signed [COORD_W-1:0] nx, ny, nz, off;
    logic signed [COORD_W-1:0] far_x, far_y, far_z, near_x, near_y, near_z;
    logic                      swap_x, swap_y, swap_z;

    logic                     r_a_valid;
    t_item                    r_a_item;
    logic signed [PROD_W-1:0] r_far_x, r_far_y, r_far_z;
    logic signed [PROD_W-1:0] r_near_x, r_near_y, r_near_z;

    logic signed [SUM_W-1:0]  far_sum, near_sum, thr;
    logic                     far_in, near_in;

    logic                     r_b_valid;
    t_item                    r_b_item;
    t_item                    n_b_item;

    assign nx  = r_plane[15:0];
    assign ny  = r_plane[31:16];
    assign nz  = r_plane[47:32];
    assign off = r_plane[63:48];

    // an axis whose minimum lies above its maximum swaps the corner choice
    assign swap_x = $signed(i_item.box.min_x) > $signed(i_item.box.max_x);
    assign swap_y = $signed(i_item.box.min_y) > $signed(i_item.box.max_y);
    assign swap_z = $signed(i_item.box.min_z) > $signed(i_item.box.max_z);

    // far corner maximizes the dot product, near corner minimizes it
    assign far_x  = (nx[COORD_W-1] ^ swap_x) ? i_item.box.min_x : i_item.box.max_x;
    assign far_y  = (ny[COORD_W-1] ^ swap_y) ? i_item.box.min_y : i_item.box.max_y;
    assign far_z  = (nz[COORD_W-1] ^ swap_z) ? i_item.box.min_z : i_item.box.max_z;
    assign near_x = (nx[COORD_W-1] ^ swap_x) ? i_item.box.max_x : i_item.box.min_x;
    assign near_y = (ny[COORD_W-1] ^ swap_y) ? i_item.box.max_y : i_item.box.min_y;
    assign near_z = (nz[COORD_W-1] ^ swap_z) ? i_item.box.max_z : i_item.box.min_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cfg_we) begin
            r_plane <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_far_x  <= far_x * nx;
            r_far_y  <= far_y * ny;
            r_far_z  <= far_z * nz;
            r_near_x <= near_x * nx;
            r_near_y <= near_y * ny;
            r_near_z <= near_z * nz;
            r_b_item <= n_b_item;
        end
    end

    assign far_sum  = $signed({{3{r_far_x[PROD_W-1]}}, r_far_x})
                    + $signed({{3{r_far_y[PROD_W-1]}}, r_far_y})
                    + $signed({{3{r_far_z[PROD_W-1]}}, r_far_z});
    assign near_sum = $signed({{3{r_near_x[PROD_W-1]}}, r_near_x})
                    + $signed({{3{r_near_y[PROD_W-1]}}, r_near_y})
                    + $signed({{3{r_near_z[PROD_W-1]}}, r_near_z});
    assign thr      = $signed({{(SUM_W-COORD_W-FRAC_BITS){off[COORD_W-1]}}, off,
                               {FRAC_BITS{1'b0}}});

    assign far_in  = far_sum > thr;
    assign near_in = near_sum > thr;

    always_comb begin
        n_b_item = r_a_item;
        if (!r_a_item.hint[PLANE_IDX]) begin
            n_b_item.any_in[PLANE_IDX] = far_in;
            n_b_item.all_in[PLANE_IDX] = near_in;
        end
    end

    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

>>> hdl/afc_result.sv
// ----------------------------------------------------------------------------
// afc_result
// folds the plane masks of the chain into the outcome and holds it in the
// output register
// ----------------------------------------------------------------------------
module afc_result (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  afc_pkg::t_item                 i_item,
    output logic                           o_valid,
    output logic [1:0]                     o_status,
    output logic [afc_pkg::PLANE_SLOTS-1:0] o_inside_mask
);
    import afc_pkg::*;

    logic                   r_valid;
    logic [1:0]             r_status, n_status;
    logic [PLANE_SLOTS-1:0] r_mask, n_mask;

    always_comb begin
        if (i_item.any_in != ALL_PLANES) begin
            n_status = ST_CULLED;
            n_mask   = '0;
        end else if (i_item.all_in == ALL_PLANES) begin
            n_status = ST_INSIDE;
            n_mask   = ALL_PLANES;
        end else begin
            n_status = ST_PARTIAL;
            n_mask   = i_item.all_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_status <= n_status;
            r_mask   <= n_mask;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_inside_mask = r_mask;

endmodule

>>> hdl/aabb_frustum_cull_top.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_top
// axis-aligned box versus six-plane view frustum cull engine
// ----------------------------------------------------------------------------
// Accepts one box per clock cycle unless o_in_stall is high and returns one
// outcome per box, in order. Each plane is a cell of two stages (six 16x16
// multiplies, then a sum and a strict compare against offset*2^14), followed
// by the output register. The whole chain holds while a result is stalled at
// the output. Plane registers must be written only while the block is idle,
// which it does not enforce; cfg port is always ready, ignores indexes past 5.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_top #(
    parameter int NUM_PLANES = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [afc_pkg::COORD_W-1:0] i_min_x,
    input  logic signed [afc_pkg::COORD_W-1:0] i_min_y,
    input  logic signed [afc_pkg::COORD_W-1:0] i_min_z,
    input  logic signed [afc_pkg::COORD_W-1:0] i_max_x,
    input  logic signed [afc_pkg::COORD_W-1:0] i_max_y,
    input  logic signed [afc_pkg::COORD_W-1:0] i_max_z,
    input  logic [afc_pkg::PLANE_SLOTS-1:0]   i_known_inside,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic [afc_pkg::PLANE_SLOTS-1:0]   o_inside_mask,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [afc_pkg::PLANE_W-1:0]       i_cfg_data
);
    import afc_pkg::*;

    localparam logic [PLANE_SLOTS-1:0] ACTIVE_MASK =
        PLANE_SLOTS'((1 << NUM_PLANES) - 1);
    localparam logic [PLANE_SLOTS-1:0] IDLE_MASK = ALL_PLANES & ~ACTIVE_MASK;

    logic  en;
    logic  chain_valid [0:NUM_PLANES];
    t_item chain_item  [0:NUM_PLANES];

    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // inactive planes count as holding every corner
    assign chain_valid[0]            = i_in_valid;
    assign chain_item[0].box.min_x   = i_min_x;
    assign chain_item[0].box.min_y   = i_min_y;
    assign chain_item[0].box.min_z   = i_min_z;
    assign chain_item[0].box.max_x   = i_max_x;
    assign chain_item[0].box.max_y   = i_max_y;
    assign chain_item[0].box.max_z   = i_max_z;
    assign chain_item[0].hint        = i_known_inside;
    assign chain_item[0].any_in      = i_known_inside | IDLE_MASK;
    assign chain_item[0].all_in      = i_known_inside | IDLE_MASK;

    for (genvar j = 0; j < NUM_PLANES; j++) begin : g_cell
        afc_cell #(
            .PLANE_IDX (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_cfg_we   (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_IDX_W'(j))),
            .i_cfg_data (i_cfg_data),
            .i_valid    (chain_valid[j]),
            .i_item     (chain_item[j]),
            .o_valid    (chain_valid[j+1]),
            .o_item     (chain_item[j+1])
        );
    end

    afc_result u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (chain_valid[NUM_PLANES]),
        .i_item        (chain_item[NUM_PLANES]),
        .o_valid       (o_out_valid),
        .o_status      (o_status),
        .o_inside_mask (o_inside_mask)
    );

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_CULLED || o_status == ST_INSIDE ||
                         o_status == ST_PARTIAL))
        else $error("status code out of range");

    a_inside_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_INSIDE) |-> (o_inside_mask == ALL_PLANES))
        else $error("fully inside without full mask");

    a_culled_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_CULLED) |-> (o_inside_mask == '0))
        else $error("culled box with nonzero mask");

    a_partial_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_PARTIAL) |-> (o_inside_mask != ALL_PLANES))
        else $error("partial box with full mask");

endmodule
